// ===== hw/rtl/mvsm_pkg.sv =====
package mvsm_pkg;

	typedef enum logic [2:0] {
		CMD_TICK        = 3'd0,
		CMD_PLAY        = 3'd1,
		CMD_WRITE_SOUND = 3'd2,
		CMD_SET_LENGTH  = 3'd3,
		CMD_WRITE_MUSIC = 3'd4,
		CMD_START_MUSIC = 3'd5,
		CMD_STOP_MUSIC  = 3'd6,
		CMD_UNUSED      = 3'd7
	} cmd_t;

	// Configuration register indexes
	localparam logic CFG_SFX_VOLUME   = 1'b0;
	localparam logic CFG_MUSIC_VOLUME = 1'b1;

	localparam logic [16:0] UNITY       = 17'd32768;
	localparam logic [15:0] SFX_RESET   = 16'd22938;
	localparam logic [15:0] MUSIC_RESET = 16'd16384;
	localparam int          SUM_W       = 21;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CMD,
		ST_MREAD,
		ST_MWAIT,
		ST_MUL_L,
		ST_MUL_R,
		ST_VSCAN,
		ST_VWAIT,
		ST_VMUL,
		ST_FIND,
		ST_OUT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;        // capture input beat
		logic exec_simple; // carry out a non-tick, non-play command
		logic tick_start;  // clear sums, start music step
		logic music_read;  // issue music store read
		logic mul_left;    // music left product
		logic mul_right;   // music right product
		logic voice_mul;   // voice product and position update
		logic voice_next;  // advance voice index
		logic find_step;   // examine one voice for a free slot
		logic play_commit; // start the chosen voice
		logic out_load;    // load output register
	} ctrl_t;

	// Datapath to controller status
	typedef struct packed {
		cmd_t cmd;
		logic music_hit;   // music frame to mix this tick
		logic voice_last;  // current voice is the last one
		logic play_ok;     // play command is valid
		logic out_busy;    // output register holds a stalled beat
	} stat_t;

endpackage

// ===== hw/rtl/multi_voice_sample_mixer_top.sv =====
// Channel | Handshake           | Payload
// input   | in_valid/in_stall   | cmd, sound_id, address, sample_left/right, length, loop_flag
// output  | out_valid/out_stall | mix_left, mix_right
// config  | cfg_valid/cfg_ready | cfg_index, cfg_data
// Non-tick commands finish in the command state; a valid play then scans every voice.
// A tick skips the music products when no music frame plays: one shared multiplier
// walks music then every voice, one sound store read per voice.
// Reset clears voices, lengths and music state; stores are not cleared.
// Output stall holds the result; the next tick waits only when the output is full.
module multi_voice_sample_mixer_top #(
	parameter int VOICE_COUNT = 16,
	parameter int SOUND_COUNT = 8,
	parameter int SOUND_DEPTH = 32768,
	parameter int MUSIC_DEPTH = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [2:0]         sound_id,
	input  logic [15:0]        address,
	input  logic signed [15:0] sample_left,
	input  logic signed [15:0] sample_right,
	input  logic [16:0]        length,
	input  logic               loop_flag,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [20:0] mix_left,
	output logic signed [20:0] mix_right,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);
	import mvsm_pkg::*;

	logic [15:0] sfx_vol_q, mus_vol_q;
	ctrl_t ctl;
	stat_t st;

	// Volume registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sfx_vol_q <= SFX_RESET;
			mus_vol_q <= MUSIC_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_MUSIC_VOLUME) mus_vol_q <= cfg_data;
			else                               sfx_vol_q <= cfg_data;
		end
	end

	mvsm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.st(st), .ctl(ctl)
	);

	mvsm_dp #(
		.VOICE_COUNT(VOICE_COUNT), .SOUND_COUNT(SOUND_COUNT),
		.SOUND_DEPTH(SOUND_DEPTH), .MUSIC_DEPTH(MUSIC_DEPTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .st(st),
		.cmd(cmd), .sound_id(sound_id), .address(address),
		.sample_left(sample_left), .sample_right(sample_right),
		.length(length), .loop_flag(loop_flag),
		.sfx_volume(sfx_vol_q), .music_volume(mus_vol_q),
		.mix_left(mix_left), .mix_right(mix_right),
		.out_valid(out_valid), .out_stall(out_stall)
	);
endmodule

// ===== hw/rtl/mvsm_ram.sv =====
module mvsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/mvsm_ctrl.sv =====
module mvsm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  mvsm_pkg::stat_t st,
	output mvsm_pkg::ctrl_t ctl
);
	import mvsm_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_CMD;
				end
			end
			ST_CMD: begin
				if (st.cmd == CMD_TICK) begin
					ctl.tick_start = 1'b1;
					state_d        = ST_MREAD;
				end else if (st.cmd == CMD_PLAY) begin
					state_d = st.play_ok ? ST_FIND : ST_IDLE;
				end else begin
					ctl.exec_simple = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_MREAD: begin
				ctl.music_read = 1'b1;
				state_d        = ST_MWAIT;
			end
			ST_MWAIT: begin
				state_d = st.music_hit ? ST_MUL_L : ST_VSCAN;
			end
			ST_MUL_L: begin
				ctl.mul_left = 1'b1;
				state_d      = ST_MUL_R;
			end
			ST_MUL_R: begin
				ctl.mul_right = 1'b1;
				state_d       = ST_VSCAN;
			end
			ST_VSCAN: begin
				state_d = ST_VWAIT;
			end
			ST_VWAIT: begin
				state_d = ST_VMUL;
			end
			ST_VMUL: begin
				ctl.voice_mul = 1'b1;
				if (st.voice_last) begin
					state_d = ST_OUT;
				end else begin
					ctl.voice_next = 1'b1;
					state_d        = ST_VSCAN;
				end
			end
			ST_OUT: begin
				if (!st.out_busy) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_FIND: begin
				ctl.find_step = 1'b1;
				if (st.voice_last) begin
					ctl.play_commit = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// A new beat is taken only from idle
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> state_q == ST_IDLE)
		else $error("input taken outside idle");
	// Output is loaded only when the register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> !st.out_busy)
		else $error("output overwritten");
	// A tick always reaches the music read
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.tick_start |=> ctl.music_read)
		else $error("tick lost");
endmodule

// ===== hw/rtl/mvsm_dp.sv =====
module mvsm_dp #(
	parameter int VOICE_COUNT = 16,
	parameter int SOUND_COUNT = 8,
	parameter int SOUND_DEPTH = 32768,
	parameter int MUSIC_DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mvsm_pkg::ctrl_t          ctl,
	output mvsm_pkg::stat_t          st,
	input  logic [2:0]               cmd,
	input  logic [2:0]               sound_id,
	input  logic [15:0]              address,
	input  logic signed [15:0]       sample_left,
	input  logic signed [15:0]       sample_right,
	input  logic [16:0]              length,
	input  logic                     loop_flag,
	input  logic [15:0]              sfx_volume,
	input  logic [15:0]              music_volume,
	output logic signed [20:0]       mix_left,
	output logic signed [20:0]       mix_right,
	output logic                     out_valid,
	input  logic                     out_stall
);
	import mvsm_pkg::*;

	localparam int VW  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int SW  = (SOUND_COUNT > 1) ? $clog2(SOUND_COUNT) : 1;
	localparam int PW  = $clog2(SOUND_DEPTH);
	localparam int MW  = $clog2(MUSIC_DEPTH);
	localparam int SAW = SW + PW;

	// Captured command
	cmd_t        cmd_q;
	logic [2:0]  id_q;
	logic [15:0] addr_q;
	logic [15:0] sl_q, sr_q;
	logic [16:0] len_q;
	logic        loop_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= cmd_t'(cmd);
			id_q   <= sound_id;
			addr_q <= address;
			sl_q   <= sample_left;
			sr_q   <= sample_right;
			len_q  <= length;
			loop_q <= loop_flag;
		end
	end

	// Voice and music state
	logic [SW-1:0]  vsound_q [VOICE_COUNT];
	logic [16:0]    vpos_q   [VOICE_COUNT];
	logic [VOICE_COUNT-1:0] vlive_q;
	logic [16:0]    slen_q   [SOUND_COUNT];
	logic [16:0]    mlen_q, mpos_q;
	logic           mloop_q;
	logic [VW-1:0]  vidx_q, pick_q;
	logic           found_q;
	logic signed [SUM_W-1:0] sum_l_q, sum_r_q;
	logic [31:0]    mframe_q;
	logic           mhit_q;

	logic id_ok;
	assign id_ok = {4'b0, id_q} < 7'(SOUND_COUNT);
	logic [SW-1:0] id_s;
	assign id_s = SW'(id_q);

	logic [16:0] len_sat_s, len_sat_m;
	assign len_sat_s = (len_q > 17'(SOUND_DEPTH)) ? 17'(SOUND_DEPTH) : len_q;
	assign len_sat_m = (len_q > 17'(MUSIC_DEPTH)) ? 17'(MUSIC_DEPTH) : len_q;

	logic [16:0] sg, mg;
	assign sg = ({1'b0, sfx_volume} > UNITY) ? UNITY : {1'b0, sfx_volume};
	assign mg = ({1'b0, music_volume} > UNITY) ? UNITY : {1'b0, music_volume};

	// Music position after wrap
	logic [16:0] mpos_eff;
	assign mpos_eff = (mpos_q >= mlen_q && mloop_q) ? 17'd0 : mpos_q;

	// Stores
	logic           snd_we, mus_we;
	logic [SAW-1:0] snd_waddr, snd_raddr;
	logic [15:0]    snd_rdata;
	logic [31:0]    mus_rdata;
	logic [MW-1:0]  mus_raddr;

	assign snd_we    = ctl.exec_simple && cmd_q == CMD_WRITE_SOUND && id_ok
			&& {1'b0, addr_q} < 17'(SOUND_DEPTH);
	assign snd_waddr = {id_s, addr_q[PW-1:0]};
	assign mus_we    = ctl.exec_simple && cmd_q == CMD_WRITE_MUSIC
			&& {1'b0, addr_q} < 17'(MUSIC_DEPTH);
	assign mus_raddr = mpos_eff[MW-1:0];

	logic [SW-1:0] cur_snd;
	logic [16:0]   cur_pos, cur_len;
	assign cur_snd   = vsound_q[vidx_q];
	assign cur_pos   = vpos_q[vidx_q];
	assign cur_len   = slen_q[cur_snd];
	assign snd_raddr = {cur_snd, cur_pos[PW-1:0]};

	mvsm_ram #(.WIDTH(16), .DEPTH(SOUND_COUNT * SOUND_DEPTH)) u_sound (
		.clk(clk), .we(snd_we), .waddr(snd_waddr), .wdata(sl_q),
		.raddr(snd_raddr), .rdata(snd_rdata)
	);
	mvsm_ram #(.WIDTH(32), .DEPTH(MUSIC_DEPTH)) u_music (
		.clk(clk), .we(mus_we), .waddr(addr_q[MW-1:0]), .wdata({sr_q, sl_q}),
		.raddr(mus_raddr), .rdata(mus_rdata)
	);

	// Shared multiplier: sample times gain, floor shift by 15
	logic signed [15:0] mul_a;
	logic [16:0]        mul_g;
	logic signed [33:0] prod;
	logic signed [SUM_W-1:0] term;
	always_comb begin
		mul_a = signed'(snd_rdata);
		mul_g = sg;
		if (ctl.mul_left) begin
			mul_a = signed'(mframe_q[15:0]);
			mul_g = mg;
		end else if (ctl.mul_right) begin
			mul_a = signed'(mframe_q[31:16]);
			mul_g = mg;
		end
		prod = 34'(mul_a) * signed'({1'b0, mul_g});
		term = SUM_W'(prod >>> 15);
	end

	logic voice_hit;
	assign voice_hit = vlive_q[vidx_q] && cur_pos < cur_len
			&& cur_pos < 17'(SOUND_DEPTH);

	logic [16:0] slen_new;
	assign slen_new = len_sat_s;

	// Control state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICE_COUNT; i++) begin
				vsound_q[i] <= '0;
				vpos_q[i]   <= '0;
			end
			for (int i = 0; i < SOUND_COUNT; i++) slen_q[i] <= '0;
			vlive_q  <= '0;
			mlen_q   <= '0;
			mpos_q   <= '0;
			mloop_q  <= 1'b1;
			vidx_q   <= '0;
			pick_q   <= '0;
			found_q  <= 1'b0;
			sum_l_q  <= '0;
			sum_r_q  <= '0;
			mhit_q   <= 1'b0;
		end else begin
			if (ctl.load) begin
				vidx_q  <= '0;
				pick_q  <= '0;
				found_q <= 1'b0;
			end
			if (ctl.exec_simple) begin
				unique case (cmd_q)
					CMD_SET_LENGTH: if (id_ok) slen_q[id_s] <= slen_new;
					CMD_START_MUSIC: begin
						mlen_q  <= len_sat_m;
						mpos_q  <= '0;
						mloop_q <= loop_q;
					end
					CMD_STOP_MUSIC: begin
						mlen_q <= '0;
						mpos_q <= '0;
					end
					default: ;
				endcase
			end
			if (ctl.tick_start) begin
				sum_l_q <= '0;
				sum_r_q <= '0;
			end
			// Music step happens at the read
			if (ctl.music_read) begin
				mhit_q <= 1'b0;
				if (mlen_q != 0) begin
					mpos_q <= mpos_eff;
					if (mpos_eff < mlen_q && mpos_eff < 17'(MUSIC_DEPTH)) begin
						mhit_q <= 1'b1;
						mpos_q <= mpos_eff + 17'd1;
					end
				end
			end
			if (ctl.mul_left)  sum_l_q <= sum_l_q + term;
			if (ctl.mul_right) sum_r_q <= sum_r_q + term;
			if (ctl.voice_mul && vlive_q[vidx_q]) begin
				if (voice_hit) begin
					sum_l_q <= sum_l_q + term;
					sum_r_q <= sum_r_q + term;
					vpos_q[vidx_q] <= cur_pos + 17'd1;
					if (cur_pos + 17'd1 >= cur_len) vlive_q[vidx_q] <= 1'b0;
				end else begin
					vlive_q[vidx_q] <= 1'b0;
				end
			end
			if (ctl.voice_next || (ctl.find_step && !ctl.play_commit)) begin
				vidx_q <= vidx_q + VW'(1);
			end
			if (ctl.find_step && !found_q && !vlive_q[vidx_q]) begin
				found_q <= 1'b1;
				pick_q  <= vidx_q;
			end
			if (ctl.play_commit) begin
				automatic logic [VW-1:0] p;
				p = (!found_q && !vlive_q[vidx_q]) ? vidx_q :
						(found_q ? pick_q : '0);
				vsound_q[p] <= id_s;
				vpos_q[p]   <= '0;
				vlive_q[p]  <= 1'b1;
				vidx_q      <= '0;
			end
		end
	end

	// Music frame hold
	always_ff @(posedge clk) begin
		if (ctl.mul_left == 1'b0 && ctl.mul_right == 1'b0) mframe_q <= mus_rdata;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			mix_left  <= sum_l_q;
			mix_right <= sum_r_q;
		end
	end

	assign st.cmd        = cmd_q;
	assign st.music_hit  = mhit_q;
	assign st.voice_last = vidx_q == VW'(VOICE_COUNT - 1);
	assign st.play_ok    = id_ok && slen_q[id_s] != 0;
	assign st.out_busy   = out_valid && out_stall;

	// A voice never sits live at or past its length after its turn
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.voice_mul && voice_hit && cur_pos + 17'd1 >= cur_len
		|=> !vlive_q[$past(vidx_q)])
		else $error("voice not freed");
	// Music position never runs past length
	assert property (@(posedge clk) disable iff (!arst_n)
		mlen_q != 0 && !mloop_q |-> mpos_q <= mlen_q)
		else $error("music overrun");
	// Play commits only on a valid play
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.play_commit |-> cmd_q == CMD_PLAY && st.play_ok)
		else $error("bad play");
endmodule
